// ----- hdl/ialu_pkg.sv -----
package ialu_pkg;

   typedef enum logic [4:0] {
      OP_NONE  = 5'd0,  OP_SLL   = 5'd1,  OP_SRL   = 5'd2,  OP_SRA   = 5'd3,
      OP_SLLV  = 5'd4,  OP_SRLV  = 5'd5,  OP_SRAV  = 5'd6,  OP_ADD   = 5'd7,
      OP_SUB   = 5'd8,  OP_AND   = 5'd9,  OP_OR    = 5'd10, OP_XOR   = 5'd11,
      OP_NOR   = 5'd12, OP_MULT  = 5'd13, OP_MULTU = 5'd14, OP_DIV   = 5'd15,
      OP_DIVU  = 5'd16, OP_SLT   = 5'd17, OP_SLTU  = 5'd18, OP_MFHI  = 5'd19,
      OP_MFLO  = 5'd20, OP_MTHI  = 5'd21, OP_MTLO  = 5'd22, OP_ADDI  = 5'd23,
      OP_SLTI  = 5'd24, OP_SLTIU = 5'd25, OP_ANDI  = 5'd26, OP_ORI   = 5'd27,
      OP_XORI  = 5'd28, OP_LUI   = 5'd29, OP_LINK  = 5'd30, OP_PASSA = 5'd31
   } action_type;

   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [31:0] WORD_MASK = 32'hffff_ffff;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] x;
      logic [31:0] y;
   } md_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_rsp_type;

endpackage

// ----- hdl/ialu_muldiv.sv -----
module ialu_muldiv (
   input  logic                    clock,
   input  logic                    reset,
   input  ialu_pkg::md_cmd_type    cmd,
   output ialu_pkg::md_rsp_type    rsp
);

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] y_ff, y_in;
   logic [32:0] sum;
   logic [32:0] trial;

   always_comb begin
      sum = {1'b0, acc_ff} + (q_ff[0] ? {1'b0, y_ff} : 33'd0);
      trial = {acc_ff, q_ff[31]} - {1'b0, y_ff};
      busy_in = busy_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      q_in = q_ff;
      y_in = y_ff;
      rsp.done = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in = cmd.is_div;
         cnt_in = 6'd0;
         acc_in = 32'd0;
         q_in = cmd.x;
         y_in = cmd.y;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!trial[32]) begin
               acc_in = trial[31:0];
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               acc_in = {acc_ff[30:0], q_ff[31]};
               q_in = {q_ff[30:0], 1'b0};
            end
         end else begin
            acc_in = sum[32:1];
            q_in = {sum[0], q_ff[31:1]};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            rsp.done = 1'b1;
         end
      end
      rsp.hi = acc_in;
      rsp.lo = q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      q_ff <= q_in;
      y_ff <= y_in;
   end

endmodule

// ----- hdl/integer_alu_with_hi_lo.sv -----
// Simple operations: result is registered in ST_EXEC and offered in ST_OUT.
// Multiply and divide (unless by zero or MIN/-1) run 32 passes through one
// shared add/subtract shifter plus sign fix-up; no beat is taken meanwhile.
// One beat in, one beat out; the next beat is taken once the result leaves.
// Synchronous active-high reset clears HI, LO and all handshake state.
module integer_alu_with_hi_lo (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[4:0], operand_a[36:5], operand_b[68:37], shift_amount[73:69],
   // immediate[89:74], link_address[121:90], zero fill to 127
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result[31:0], store_data[63:32]
   output logic [63:0]  rsp_tdata
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_EXEC = 5'b00010, ST_WAIT = 5'b00100,
      ST_FIX = 5'b01000, ST_OUT = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  act_ff;
   logic [31:0] a_ff, b_ff, link_ff, res_ff, hi_ff, lo_ff;
   logic [4:0]  sh_ff;
   logic [15:0] imm_ff;
   logic        neg_q_ff, neg_r_ff;
   logic [31:0] pend_hi_ff, pend_lo_ff;
   ialu_pkg::md_cmd_type cmd;
   ialu_pkg::md_rsp_type mrsp;

   ialu_muldiv u_md (.clock(clock), .reset(reset), .cmd(cmd), .rsp(mrsp));

   logic [31:0] simm, res_c, mag_a, mag_b, sra_b;
   logic [63:0] prod_neg;
   logic        signed_op, skip;

   always_comb begin
      simm = {{16{imm_ff[15]}}, imm_ff};
      mag_a = a_ff[31] ? (32'd0 - a_ff) : a_ff;
      mag_b = b_ff[31] ? (32'd0 - b_ff) : b_ff;
      sra_b = $signed(b_ff) >>> (act_ff == ialu_pkg::OP_SRA ? sh_ff : a_ff[4:0]);
      res_c = 32'd0;
      case (act_ff)
         ialu_pkg::OP_SLL:   res_c = b_ff << sh_ff;
         ialu_pkg::OP_SRL:   res_c = b_ff >> sh_ff;
         ialu_pkg::OP_SRA:   res_c = sra_b;
         ialu_pkg::OP_SLLV:  res_c = b_ff << a_ff[4:0];
         ialu_pkg::OP_SRLV:  res_c = b_ff >> a_ff[4:0];
         ialu_pkg::OP_SRAV:  res_c = sra_b;
         ialu_pkg::OP_ADD:   res_c = a_ff + b_ff;
         ialu_pkg::OP_SUB:   res_c = a_ff - b_ff;
         ialu_pkg::OP_AND:   res_c = a_ff & b_ff;
         ialu_pkg::OP_OR:    res_c = a_ff | b_ff;
         ialu_pkg::OP_XOR:   res_c = a_ff ^ b_ff;
         ialu_pkg::OP_NOR:   res_c = ~(a_ff | b_ff);
         ialu_pkg::OP_SLT:   res_c = {31'd0, $signed(a_ff) < $signed(b_ff)};
         ialu_pkg::OP_SLTU:  res_c = {31'd0, a_ff < b_ff};
         ialu_pkg::OP_MFHI:  res_c = hi_ff;
         ialu_pkg::OP_MFLO:  res_c = lo_ff;
         ialu_pkg::OP_ADDI:  res_c = a_ff + simm;
         ialu_pkg::OP_SLTI:  res_c = {31'd0, $signed(a_ff) < $signed(simm)};
         ialu_pkg::OP_SLTIU: res_c = {31'd0, a_ff < simm};
         ialu_pkg::OP_ANDI:  res_c = a_ff & {16'd0, imm_ff};
         ialu_pkg::OP_ORI:   res_c = a_ff | {16'd0, imm_ff};
         ialu_pkg::OP_XORI:  res_c = a_ff ^ {16'd0, imm_ff};
         ialu_pkg::OP_LUI:   res_c = {imm_ff, 16'd0};
         ialu_pkg::OP_LINK:  res_c = link_ff;
         ialu_pkg::OP_PASSA: res_c = a_ff;
         default:            res_c = 32'd0;
      endcase
      signed_op = (act_ff == ialu_pkg::OP_MULT) || (act_ff == ialu_pkg::OP_DIV);
      skip = (b_ff == 32'd0) ||
             ((act_ff == ialu_pkg::OP_DIV) && (a_ff == ialu_pkg::SIGN_BIT) &&
              (b_ff == ialu_pkg::WORD_MASK));
      cmd.start = 1'b0;
      cmd.is_div = (act_ff == ialu_pkg::OP_DIV) || (act_ff == ialu_pkg::OP_DIVU);
      cmd.x = signed_op ? mag_a : a_ff;
      cmd.y = signed_op ? mag_b : b_ff;
      prod_neg = 64'd0 - {pend_hi_ff, pend_lo_ff};
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: begin
            if ((act_ff == ialu_pkg::OP_MULT) || (act_ff == ialu_pkg::OP_MULTU) ||
                (cmd.is_div && !skip)) begin
               cmd.start = 1'b1;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_WAIT: if (mrsp.done) state_in = ST_FIX;
         ST_FIX:  state_in = ST_OUT;
         ST_OUT:  if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {b_ff, res_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hi_ff <= 32'd0;
         lo_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EXEC) begin
            if (act_ff == ialu_pkg::OP_MTHI) hi_ff <= a_ff;
            if (act_ff == ialu_pkg::OP_MTLO) lo_ff <= a_ff;
         end
         if (state_ff == ST_FIX) begin
            if (cmd.is_div) begin
               lo_ff <= neg_q_ff ? (32'd0 - pend_lo_ff) : pend_lo_ff;
               hi_ff <= neg_r_ff ? (32'd0 - pend_hi_ff) : pend_hi_ff;
            end else if (neg_q_ff) begin
               hi_ff <= prod_neg[63:32];
               lo_ff <= prod_neg[31:0];
            end else begin
               hi_ff <= pend_hi_ff;
               lo_ff <= pend_lo_ff;
            end
         end
      end
      if (req_tvalid && req_tready) begin
         act_ff <= req_tdata[4:0];
         a_ff <= req_tdata[36:5];
         b_ff <= req_tdata[68:37];
         sh_ff <= req_tdata[73:69];
         imm_ff <= req_tdata[89:74];
         link_ff <= req_tdata[121:90];
      end
      if (state_ff == ST_EXEC) begin
         res_ff <= res_c;
         neg_q_ff <= signed_op && (a_ff[31] ^ b_ff[31]);
         neg_r_ff <= signed_op && a_ff[31];
      end
      if (mrsp.done) begin
         pend_hi_ff <= mrsp.hi;
         pend_lo_ff <= mrsp.lo;
      end
   end

endmodule
